/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the handle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define HTA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define HTA_ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define HTA_ASSERT(name, clk, rst, prop, msg)
`define HTA_ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

/* hw/rtl/hta_pkg.sv */
// Types, codes and helpers shared by the handle table allocator modules.
`timescale 1ns / 1ps

package hta_pkg;

  // Stream word layout
  localparam int CMD_W       = 2;
  localparam int OBJ_FIELD_W = 32;
  localparam int HANDLE_W    = 10;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Active bits are kept in rows of this many slots
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_UNDEF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  localparam logic signed [1:0] DELTA_ZERO  = 2'sb00;
  localparam logic signed [1:0] DELTA_PLUS  = 2'sb01;
  localparam logic signed [1:0] DELTA_MINUS = 2'sb11;

  // Which result the output register is loaded with
  typedef enum logic [2:0] {
    RES_NULL    = 3'd0,
    RES_FULL    = 3'd1,
    RES_INVALID = 3'd2,
    RES_CREATE  = 3'd3,
    RES_LOOKUP  = 3'd4,
    RES_CLOSE   = 3'd5
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EVAL = 2'd2,
    S_RESP = 2'd3
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // input word accepted
    logic rd_handle;  // read row and object at the input handle
    logic rd_scan;    // read row picked by the segment scan
    logic seg_inc;    // move scan to next segment
    logic upd_set;    // claim lowest free slot of current row
    logic upd_clr;    // free current slot
    logic latch;      // capture result slot and object
    logic out_load;   // load output register
    res_t res;
  } hta_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  in_op;
    logic in_null;
    logic in_bad;
    logic seg_free;
    logic seg_last;
    logic slot_active;
    logic out_free;
  } hta_stat_t;

  // Index of the lowest clear bit; zero when all bits are set
  function automatic logic [ROW_BW-1:0] lowest_zero(input logic [ROW_W-1:0] w);
    logic [ROW_BW-1:0] idx;
    idx = '0;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (!w[k]) idx = ROW_BW'(k);
    end
    return idx;
  endfunction

endpackage

/* hw/rtl/hta_ctrl.sv */
// Controller state machine of the handle table allocator.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hta_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  hta_pkg::hta_stat_t stat,
  output hta_pkg::hta_cmd_t  cmd
);
  import hta_pkg::*;

  state_t state, state_next;
  res_t   res, res_next;
  op_t    op, op_next;

  // State and held item info
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    res <= res_next;
    op  <= op_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    res_next   = res;
    op_next    = op;
    cmd        = '0;
    cmd.res    = res;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture   = 1'b1;
          cmd.rd_handle = 1'b1;
          op_next       = stat.in_op;
          if (stat.in_op == OP_CREATE) begin
            if (stat.in_null) begin
              res_next   = RES_NULL;
              state_next = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end else if (stat.in_bad) begin
            res_next   = RES_INVALID;
            state_next = S_RESP;
          end else begin
            state_next = S_EVAL;
          end
        end
      end
      S_SCAN: begin
        if (stat.seg_free) begin
          cmd.rd_scan = 1'b1;
          state_next  = S_EVAL;
        end else if (stat.seg_last) begin
          res_next   = RES_FULL;
          state_next = S_RESP;
        end else begin
          cmd.seg_inc = 1'b1;
        end
      end
      S_EVAL: begin
        cmd.latch  = 1'b1;
        state_next = S_RESP;
        if (op == OP_CREATE) begin
          cmd.upd_set = 1'b1;
          res_next    = RES_CREATE;
        end else if (!stat.slot_active) begin
          res_next = RES_INVALID;
        end else if (op == OP_LOOKUP) begin
          res_next = RES_LOOKUP;
        end else begin
          cmd.upd_clr = 1'b1;
          res_next    = RES_CLOSE;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  `HTA_ASSERT(a_accept_leaves_idle, clk, rst, s_tvalid && s_tready |=> state != S_IDLE, "accepted word did not start work")
  `HTA_ASSERT(a_load_when_free, clk, rst, cmd.out_load |-> stat.out_free, "output register overwritten")

endmodule

/* hw/rtl/hta_datapath.sv */
// Datapath: active-bit rows, row-full flags, object memory and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hta_datapath #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int OBJECT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [hta_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [hta_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  hta_pkg::hta_cmd_t                  cmd,
  output hta_pkg::hta_stat_t                 stat
);
  import hta_pkg::*;

  localparam int ROWS     = (TABLE_DEPTH + ROW_W - 1) / ROW_W;
  localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NROW     = 2 ** RAW;
  localparam int SW       = RAW + ROW_BW;
  localparam int NSLOT    = 2 ** SW;
  localparam int SGW      = (RAW > ROW_BW) ? RAW - ROW_BW : 1;
  localparam int NSEG     = 2 ** SGW;
  localparam int SEG_LAST = (ROWS - 1) / ROW_W;
  localparam int LAST_N   = TABLE_DEPTH - (ROWS - 1) * ROW_W;
  localparam logic [ROW_W-1:0] LAST_PAD =
    (LAST_N == ROW_W) ? '0 : ~((ROW_W'(1) << LAST_N) - ROW_W'(1));

  // Input word fields
  op_t                   in_op;
  logic [OBJECT_WIDTH-1:0] in_obj;
  logic [HANDLE_W-1:0]   in_handle;
  logic [SW-1:0]         h_slot;
  logic [RAW-1:0]        h_row;

  assign in_op     = op_t'(s_tdata[CMD_W-1:0]);
  assign in_obj    = OBJECT_WIDTH'(s_tdata[CMD_W+OBJ_FIELD_W-1:CMD_W]);
  assign in_handle = s_tdata[CMD_W+OBJ_FIELD_W+HANDLE_W-1:CMD_W+OBJ_FIELD_W];
  assign h_slot    = SW'(in_handle);
  assign h_row     = h_slot[SW-1:ROW_BW];

  // Storage
  logic [ROW_W-1:0]        row_mem [NROW];
  logic [OBJECT_WIDTH-1:0] obj_mem [NSLOT];
  logic [NROW-1:0]         row_valid;
  logic [NROW-1:0]         row_full;

  // Item context
  logic [OBJECT_WIDTH-1:0] obj_q;
  logic [RAW-1:0]          cur_row;
  logic [ROW_BW-1:0]       cur_bit;
  logic [SGW-1:0]          seg_idx;
  logic [ROW_W-1:0]        row_rdata;
  logic [OBJECT_WIDTH-1:0] obj_rdata;
  logic [SW-1:0]           res_slot;
  logic [OBJECT_WIDTH-1:0] res_obj;

  // Segment scan over row-full flags
  logic [NSEG*ROW_W-1:0] full_pad;
  logic [ROW_W-1:0]      seg_word;
  logic [ROW_BW-1:0]     scan_bit;
  logic [RAW-1:0]        scan_row;
  logic                  seg_last;

  always_comb begin
    full_pad = '1;
    full_pad[ROWS-1:0] = row_full[ROWS-1:0];
  end

  assign seg_word = full_pad[{seg_idx, ROW_BW'(0)} +: ROW_W];
  assign scan_bit = lowest_zero(seg_word);
  assign scan_row = RAW'({seg_idx, scan_bit});
  assign seg_last = (seg_idx == SGW'(SEG_LAST));

  // Current row view: reserved slot 0 and slots past the table count as taken
  logic [ROW_W-1:0]  cur_word;
  logic [ROW_W-1:0]  cur_pad;
  logic [ROW_BW-1:0] free_bit;
  logic [ROW_W-1:0]  set_word;
  logic [ROW_W-1:0]  clr_word;
  logic              slot_active;

  always_comb begin
    cur_word = row_valid[cur_row] ? row_rdata : '0;
    cur_pad  = '0;
    if (cur_row == '0) cur_pad[0] = 1'b1;
    if (cur_row == RAW'(ROWS - 1)) cur_pad = cur_pad | LAST_PAD;
  end

  assign free_bit    = lowest_zero(cur_word | cur_pad);
  assign set_word    = cur_word | (ROW_W'(1) << free_bit);
  assign clr_word    = cur_word & ~(ROW_W'(1) << cur_bit);
  assign slot_active = cur_word[cur_bit];

  // Capture and scan position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      obj_q   <= in_obj;
      cur_row <= h_row;
      cur_bit <= h_slot[ROW_BW-1:0];
    end else if (cmd.rd_scan) begin
      cur_row <= scan_row;
    end
    if (rst || cmd.capture) begin
      seg_idx <= '0;
    end else if (cmd.seg_inc) begin
      seg_idx <= seg_idx + SGW'(1);
    end
  end

  // Row memory
  always_ff @(posedge clk) begin
    if (cmd.rd_handle || cmd.rd_scan) begin
      row_rdata <= row_mem[cmd.rd_scan ? scan_row : h_row];
    end
    if (cmd.upd_set) begin
      row_mem[cur_row] <= set_word;
    end else if (cmd.upd_clr) begin
      row_mem[cur_row] <= clr_word;
    end
  end

  // Object memory
  always_ff @(posedge clk) begin
    if (cmd.rd_handle) begin
      obj_rdata <= obj_mem[h_slot];
    end
    if (cmd.upd_set) begin
      obj_mem[{cur_row, free_bit}] <= obj_q;
    end
  end

  // Row flags
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (cmd.upd_set) begin
      row_valid[cur_row] <= 1'b1;
      row_full[cur_row]  <= &(set_word | cur_pad);
    end else if (cmd.upd_clr) begin
      row_full[cur_row] <= 1'b0;
    end
  end

  // Result capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_slot <= cmd.upd_set ? {cur_row, free_bit} : {cur_row, cur_bit};
      res_obj  <= cmd.upd_set ? obj_q : obj_rdata;
    end
  end

  // Output register
  status_t             out_status;
  logic [HANDLE_W-1:0] out_handle;
  logic [OBJ_FIELD_W-1:0] out_obj;
  logic signed [1:0]   out_ref;
  logic signed [1:0]   out_hcd;
  logic                out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_handle <= '0;
      out_obj    <= '0;
      out_ref    <= DELTA_ZERO;
      out_hcd    <= DELTA_ZERO;
      unique case (cmd.res)
        RES_NULL:    out_status <= ST_NULL;
        RES_FULL:    out_status <= ST_FULL;
        RES_CREATE: begin
          out_status <= ST_OK;
          out_handle <= HANDLE_W'(res_slot);
          out_obj    <= OBJ_FIELD_W'(res_obj);
          out_ref    <= DELTA_PLUS;
          out_hcd    <= DELTA_PLUS;
        end
        RES_LOOKUP: begin
          out_status <= ST_OK;
          out_handle <= HANDLE_W'(res_slot);
          out_obj    <= OBJ_FIELD_W'(res_obj);
          out_ref    <= DELTA_PLUS;
        end
        RES_CLOSE: begin
          out_status <= ST_OK;
          out_handle <= HANDLE_W'(res_slot);
          out_obj    <= OBJ_FIELD_W'(res_obj);
          out_ref    <= DELTA_MINUS;
          out_hcd    <= DELTA_MINUS;
        end
        default:     out_status <= ST_INVALID;
      endcase
    end
  end

  assign m_tdata = {out_hcd, out_ref, out_obj, out_handle, out_status};

  // Status to controller
  always_comb begin
    stat.in_op       = in_op;
    stat.in_null     = (in_obj == '0);
    stat.in_bad      = (in_op == OP_UNDEF) || (in_handle == '0) ||
                       (32'(in_handle) >= 32'(TABLE_DEPTH));
    stat.seg_free    = ~&seg_word;
    stat.seg_last    = seg_last;
    stat.slot_active = slot_active;
    stat.out_free    = out_free;
  end

  `HTA_ASSERT(a_create_not_reserved, clk, rst, cmd.out_load && (cmd.res == RES_CREATE) |-> res_slot != '0, "slot 0 handed out")
  `HTA_ASSERT(a_scan_in_range, clk, rst, cmd.seg_inc |-> !seg_last, "scan ran past last segment")
  `HTA_ASSERT(a_close_active_only, clk, rst, cmd.upd_clr |-> slot_active, "freeing an inactive slot")

endmodule

/* hw/rtl/handle_table_allocator.sv */
// Handle table allocator: lowest-free slot create, lookup and close.
// Steps after a word is accepted: lookup/close evaluate the slot and respond; create first
//   scans the row-full flags, one group of 32 rows after another (row-full flags are searched
//   32 at a time), then evaluates and responds; a null object or a bad handle goes straight
//   to respond. Responding waits while the previous result word has not been taken.
// Flow: one word at a time; next word taken the cycle the result is valid.
// Reset: synchronous; row flags clear at once, no memory clearing pass.
`timescale 1ns / 1ps

module handle_table_allocator #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int OBJECT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // cmd[1:0], object_id[33:2], handle_in[43:34], zero [47:44]
  input  logic [hta_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[1:0], handle_out[11:2], object_out[43:12], ref_delta[45:44],
  // handle_count_delta[47:46]
  output logic [hta_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import hta_pkg::*;

  hta_cmd_t  cmd;
  hta_stat_t stat;

  hta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hta_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .OBJECT_WIDTH (OBJECT_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the handle table allocator stream block.
`timescale 1ns / 1ps

module tb_top;
  import hta_pkg::*;

  localparam int SLOTS          = 1024;
  localparam int OBJ_W          = 32;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 270;
  localparam int FILL_LIVE      = 70;

  // One result word, unpacked
  typedef struct packed {
    status_t           status;
    logic [9:0]        handle;
    logic [OBJ_W-1:0]  obj;
    logic signed [1:0] ref_d;
    logic signed [1:0] count_d;
  } table_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Shadow copy of the table
  bit               slot_live [SLOTS];
  logic [OBJ_W-1:0] slot_obj  [SLOTS];
  logic [9:0]       live_handles [$];

  table_result_t pending_results [$];
  int            errors;
  bit            src_waits;
  bit            sink_waits;
  int            quiet_cycles;

  handle_table_allocator #(
    .TABLE_DEPTH (SLOTS),
    .OBJECT_WIDTH(OBJ_W)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one command to the shadow table and return the result it gives
  function automatic table_result_t table_apply(op_t op, logic [OBJ_W-1:0] obj_id,
                                                logic [9:0] hnd);
    table_result_t r;
    int            idx;
    r.status  = ST_INVALID;
    r.handle  = '0;
    r.obj     = '0;
    r.ref_d   = DELTA_ZERO;
    r.count_d = DELTA_ZERO;
    idx       = 0;
    case (op)
      OP_CREATE: begin
        if (obj_id == '0) begin
          r.status = ST_NULL;
        end else begin
          // lowest free slot, slot 0 reserved
          for (int i = 1; i < SLOTS; i++) begin
            if (!slot_live[i]) begin
              idx = i;
              break;
            end
          end
          if (idx == 0) begin
            r.status = ST_FULL;
          end else begin
            slot_live[idx] = 1'b1;
            slot_obj[idx]  = obj_id;
            live_handles.push_back(10'(idx));
            r.status  = ST_OK;
            r.handle  = 10'(idx);
            r.obj     = obj_id;
            r.ref_d   = DELTA_PLUS;
            r.count_d = DELTA_PLUS;
          end
        end
      end
      OP_LOOKUP, OP_CLOSE: begin
        if (hnd != '0 && slot_live[hnd]) begin
          r.status = ST_OK;
          r.handle = hnd;
          r.obj    = slot_obj[hnd];
          if (op == OP_LOOKUP) begin
            r.ref_d = DELTA_PLUS;
          end else begin
            r.ref_d        = DELTA_MINUS;
            r.count_d      = DELTA_MINUS;
            slot_live[hnd] = 1'b0;
            slot_obj[hnd]  = '0;
            for (int k = 0; k < live_handles.size(); k++) begin
              if (live_handles[k] == hnd) begin
                live_handles.delete(k);
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one word, wait for the handshake, then record its expected result
  task automatic send_word(op_t op, logic [OBJ_W-1:0] obj_id, logic [9:0] hnd);
    int gap;
    gap = src_waits ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, hnd, obj_id, op};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    pending_results.push_back(table_apply(op, obj_id, hnd));
  endtask

  // Stop offering words and wait until every expected result has come
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_live();
    if (live_handles.size() == 0) return 10'($urandom);
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  function automatic logic [OBJ_W-1:0] pick_object();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '1;
    if (r < 8) return 32'h0000_0001;
    if (r < 10) return 32'h8000_0000;
    return ($urandom == 0) ? 32'h1 : $urandom;
  endfunction

  // Edges of every command and each special case
  task automatic test_directed();
    src_waits  = 1'b1;
    sink_waits = 1'b1;
    send_word(OP_CREATE, 32'h0000_0000, 10'h000);   // null object
    send_word(OP_CREATE, 32'hFFFF_FFFF, 10'h3FF);   // slot 1
    send_word(OP_CREATE, 32'h0000_0001, 10'h000);   // slot 2
    send_word(OP_CREATE, 32'h8000_0000, 10'h155);   // slot 3
    send_word(OP_LOOKUP, 32'h0000_0000, 10'h001);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 10'h002);
    send_word(OP_LOOKUP, 32'h0000_0000, 10'h003);
    send_word(OP_LOOKUP, 32'h0000_0000, 10'h000);   // reserved handle
    send_word(OP_CLOSE,  32'h0000_0000, 10'h000);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 10'h3FF);   // inactive top slot
    send_word(OP_CLOSE,  32'h0000_0000, 10'h3FF);
    send_word(OP_CLOSE,  32'h0000_0000, 10'h002);
    send_word(OP_LOOKUP, 32'h0000_0000, 10'h002);   // closed handle
    send_word(OP_CLOSE,  32'h0000_0000, 10'h002);   // double close
    send_word(OP_CREATE, 32'h5A5A_A5A5, 10'h2AA);   // reuses slot 2
    send_word(OP_UNDEF,  32'h0000_0000, 10'h001);   // undefined on live handle
    send_word(OP_UNDEF,  32'hFFFF_FFFF, 10'h000);
    send_word(OP_UNDEF,  32'h1234_5678, 10'h3FF);
    send_word(OP_CLOSE,  32'hFFFF_FFFF, 10'h001);
    send_word(OP_CLOSE,  32'h0000_0000, 10'h003);
    send_word(OP_CLOSE,  32'h0000_0000, 10'h002);
    send_word(OP_LOOKUP, 32'h0000_0000, 10'h001);
  endtask

  // Fill past two row boundaries, punch holes, refill, then free everything
  task automatic test_fill_rows();
    logic [9:0] h;
    src_waits  = 1'b0;
    sink_waits = 1'b0;
    while (live_handles.size() < FILL_LIVE) begin
      if (live_handles.size() == FILL_LIVE / 2) begin
        src_waits  = 1'b1;
        sink_waits = 1'b1;
      end
      send_word(OP_CREATE, pick_object() | 32'h1, 10'($urandom));
    end
    send_word(OP_CREATE, 32'h0000_0000, 10'h001);       // null object
    send_word(OP_LOOKUP, 32'h0, 10'(FILL_LIVE));        // last slot handed out
    send_word(OP_LOOKUP, 32'h0, 10'(FILL_LIVE + 1));    // first free slot
    repeat (6) begin
      send_word(OP_CLOSE, 32'h0, pick_live());
    end
    repeat (8) begin
      send_word(OP_CREATE, pick_object() | 32'h1, 10'($urandom));
    end
    // free everything in random order
    while (live_handles.size() != 0) begin
      src_waits  = $urandom_range(0, 1);
      sink_waits = $urandom_range(0, 1);
      h = pick_live();
      if ($urandom_range(0, 7) == 0) send_word(OP_LOOKUP, 32'($urandom), h);
      send_word(OP_CLOSE, 32'($urandom), h);
    end
  endtask

  // Mostly valid traffic on live handles, some noise, changing idle patterns
  task automatic test_random();
    int r;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        src_waits  = $urandom_range(0, 1);
        sink_waits = $urandom_range(0, 1);
      end
      // hold off until the block has emptied out
      if (n == 90 || n == 180) wait_results_drained();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_word(OP_CREATE, ($urandom_range(0, 9) == 0) ? 32'h0 : pick_object(),
                  10'($urandom));
      end else if (r < 65) begin
        send_word(OP_LOOKUP, 32'($urandom), pick_live());
      end else if (r < 85) begin
        send_word(OP_CLOSE, 32'($urandom), pick_live());
      end else if (r < 93) begin
        send_word(($urandom_range(0, 1) != 0) ? OP_LOOKUP : OP_CLOSE, 32'($urandom),
                  10'($urandom));
      end else if (r < 97) begin
        send_word(OP_UNDEF, 32'($urandom), ($urandom_range(0, 1) != 0) ? pick_live()
                  : 10'($urandom));
      end else begin
        send_word(op_t'($urandom_range(1, 2)), 32'($urandom), 10'h000);
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    errors     = 0;
    src_waits  = 1'b0;
    sink_waits = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_rows();
    test_random();

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("handle_table_allocator regression: pass");
    end else begin
      $display("handle_table_allocator regression: fail");
    end
    $finish;
  end

  // Result sink with random back-pressure, checks each word in order
  initial begin
    table_result_t exp_r;
    table_result_t got_r;
    int            stall;
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      stall = sink_waits ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      got_r.status  = status_t'(m_tdata[1:0]);
      got_r.handle  = m_tdata[11:2];
      got_r.obj     = m_tdata[43:12];
      got_r.ref_d   = m_tdata[45:44];
      got_r.count_d = m_tdata[47:46];
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, got_r.status);
          errors++;
        end
        if (got_r.handle !== exp_r.handle) begin
          $error("handle_out: expected %0d, actual %0d", exp_r.handle, got_r.handle);
          errors++;
        end
        if (got_r.obj !== exp_r.obj) begin
          $error("object_out: expected %h, actual %h", exp_r.obj, got_r.obj);
          errors++;
        end
        if (got_r.ref_d !== exp_r.ref_d) begin
          $error("ref_delta: expected %0d, actual %0d", exp_r.ref_d, got_r.ref_d);
          errors++;
        end
        if (got_r.count_d !== exp_r.count_d) begin
          $error("handle_count_delta: expected %0d, actual %0d", exp_r.count_d,
                 got_r.count_d);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("handle_table_allocator regression: fail");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/hta_pkg.sv
hw/rtl/hta_ctrl.sv
hw/rtl/hta_datapath.sv
hw/rtl/handle_table_allocator.sv
tb/tb_top.sv
